// ----- rtl/e2c_pkg.sv -----
// ----------------------------------------------------------------------------
// e2c_pkg
// Types and constants shared by the epoch-to-calendar converter.
// ----------------------------------------------------------------------------
package e2c_pkg;

	localparam int NUM_STAGES = 7;

	typedef struct packed {
		logic [31:0] epoch_seconds;
	} stamp_t;

	typedef struct packed {
		logic [5:0]  second_of_minute;
		logic [5:0]  minute_of_hour;
		logic [4:0]  hour_of_day;
		logic [4:0]  day_of_month;
		logic [2:0]  day_of_week;
		logic [3:0]  month_number;
		logic [11:0] full_year;
	} calendar_t;

	typedef struct packed {
		logic [NUM_STAGES-1:0] load;
	} pipe_ctrl_t;

	// reciprocals: floor(x * RECIP >> SHIFT) is exact over the value range used
	localparam logic [25:0] DAY_RECIP      = 26'd50903317; // 1/675, (t >> 7)
	localparam int          DAY_SHIFT      = 35;
	localparam logic [16:0] CYCLE_RECIP    = 17'd91868;    // 1/1461
	localparam int          CYCLE_SHIFT    = 27;
	localparam logic [16:0] WEEK_RECIP     = 17'd74899;    // 1/7
	localparam int          WEEK_SHIFT     = 19;
	localparam logic [16:0] HOUR_RECIP     = 17'd74566;    // 1/3600
	localparam int          HOUR_SHIFT     = 28;
	localparam logic [12:0] MIN_RECIP      = 13'd4370;     // 1/60
	localparam int          MIN_SHIFT      = 18;

	localparam logic [16:0] SECS_PER_DAY   = 17'd86400;
	localparam logic [11:0] SECS_PER_HOUR  = 12'd3600;
	localparam logic [5:0]  SECS_PER_MIN   = 6'd60;
	localparam logic [2:0]  WEEK_DAYS      = 3'd7;
	localparam logic [2:0]  EPOCH_WEEKDAY  = 3'd4;

	// day count is rebased to 1968-01-01 so each four-year cycle opens with a leap year
	localparam logic [10:0] CYCLE_DAYS     = 11'd1461;
	localparam logic [9:0]  EPOCH_REBASE   = 10'd731;
	localparam logic [11:0] YEAR_BASE      = 12'd1968;
	localparam logic [10:0] YEAR2_START    = 11'd366;
	localparam logic [10:0] YEAR3_START    = 11'd731;
	localparam logic [10:0] YEAR4_START    = 11'd1096;
	// first day after 28 Feb 2100, which is not a leap year
	localparam logic [15:0] SKIP_LEAP_DAY  = 16'd47541;

	function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
		logic [8:0] base;
		case (m)
			4'd0:    base = 9'd0;
			4'd1:    base = 9'd31;
			4'd2:    base = 9'd59;
			4'd3:    base = 9'd90;
			4'd4:    base = 9'd120;
			4'd5:    base = 9'd151;
			4'd6:    base = 9'd181;
			4'd7:    base = 9'd212;
			4'd8:    base = 9'd243;
			4'd9:    base = 9'd273;
			4'd10:   base = 9'd304;
			4'd11:   base = 9'd334;
			default: base = 9'd0;
		endcase
		return base + 9'((leap && (m >= 4'd2)) ? 1 : 0);
	endfunction

endpackage

// ----- rtl/e2c_stream_if.sv -----
// ----------------------------------------------------------------------------
// e2c_stream_if
// Valid/ready channel carrying one payload word per request.
// ----------------------------------------------------------------------------
interface e2c_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/e2c_pipe_ctrl.sv -----
// ----------------------------------------------------------------------------
// e2c_pipe_ctrl
// Stage valid bits and per-stage load enables; bubbles collapse on a stall.
// ----------------------------------------------------------------------------
module e2c_pipe_ctrl
	import e2c_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	output pipe_ctrl_t ctrl
);
	logic [NUM_STAGES-1:0] valid_q;
	logic [NUM_STAGES-1:0] adv;

	always_comb begin
		adv[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || out_ready;
		for (int k = NUM_STAGES - 2; k >= 0; k--) begin
			adv[k] = !valid_q[k] || adv[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (adv[0]) begin
				valid_q[0] <= in_valid;
			end
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (adv[k]) begin
					valid_q[k] <= valid_q[k-1];
				end
			end
		end
	end

	assign ctrl.load = adv;
	assign in_ready  = adv[0];
	assign out_valid = valid_q[NUM_STAGES-1];
endmodule

// ----- rtl/epoch_to_calendar_converter.sv -----
// ----------------------------------------------------------------------------
// epoch_to_calendar_converter
// Unix seconds to UTC second, minute, hour, weekday, day, month and year.
//
//   channel    role    payload      request
//   stamp      sink    stamp_t      one epoch count
//   calendar   source  calendar_t   one date and time of day
//
// Seven register stages; a request is taken every cycle unless a stall has
// filled the stages. Divisions are reciprocal multiplies spread over the
// stages, and the year and month come from four-year cycle arithmetic and a
// month table.
// Reset clears the stage valid bits only. A stall at the output holds the
// full stages; empty stages keep filling, so no request is lost or repeated.
// ----------------------------------------------------------------------------
module epoch_to_calendar_converter
	import e2c_pkg::*;
(
	input logic clk,
	input logic arst_n,
	e2c_stream_if.sink   stamp,
	e2c_stream_if.source calendar
);
	pipe_ctrl_t ctrl;

	e2c_pipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (stamp.valid),
		.in_ready  (stamp.ready),
		.out_valid (calendar.valid),
		.out_ready (calendar.ready),
		.ctrl      (ctrl)
	);

	logic [31:0] t_s1;
	logic [50:0] pday_s1;

	logic [16:0] tlo_s2;
	logic [16:0] dsec_s2;
	logic [15:0] d2_s2;
	logic [15:0] wx_s2;

	logic [16:0] rem_s3;
	logic [32:0] pcyc_s3;
	logic [32:0] pwk_s3;
	logic [15:0] d2_s3;
	logic [15:0] wx_s3;

	logic [33:0] phr_s4;
	logic [16:0] rem_s4;
	logic [5:0]  cyc_s4;
	logic [10:0] r_s4;
	logic [2:0]  wday_s4;

	logic [4:0]  hour_s5;
	logic [11:0] rem2_s5;
	logic [8:0]  doy_s5;
	logic        leap_s5;
	logic [11:0] year_s5;
	logic [2:0]  wday_s5;

	logic [24:0] pmin_s6;
	logic [11:0] rem2_s6;
	logic [4:0]  hour_s6;
	logic [8:0]  doy_s6;
	logic        leap_s6;
	logic [3:0]  mon_s6;
	logic [11:0] year_s6;
	logic [2:0]  wday_s6;

	calendar_t   out_s7;

	logic [15:0] days;
	logic [13:0] wq;
	logic [5:0]  cyc;
	logic [4:0]  hour;
	logic [1:0]  yoff;
	logic [10:0] ystart;
	logic [3:0]  mon;
	logic [5:0]  minute;

	assign days   = pday_s1[DAY_SHIFT+15:DAY_SHIFT];
	assign wq     = pwk_s3[WEEK_SHIFT+13:WEEK_SHIFT];
	assign cyc    = pcyc_s3[CYCLE_SHIFT+5:CYCLE_SHIFT];
	assign hour   = phr_s4[HOUR_SHIFT+4:HOUR_SHIFT];
	assign minute = pmin_s6[MIN_SHIFT+5:MIN_SHIFT];

	always_comb begin
		if (r_s4 >= YEAR4_START) begin
			yoff   = 2'd3;
			ystart = YEAR4_START;
		end else if (r_s4 >= YEAR3_START) begin
			yoff   = 2'd2;
			ystart = YEAR3_START;
		end else if (r_s4 >= YEAR2_START) begin
			yoff   = 2'd1;
			ystart = YEAR2_START;
		end else begin
			yoff   = 2'd0;
			ystart = '0;
		end
	end

	always_comb begin
		mon = '0;
		for (int i = 1; i < 12; i++) begin
			if (doy_s5 >= month_start(4'(i), leap_s5)) begin
				mon = 4'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load[0]) begin
			t_s1    <= stamp.payload.epoch_seconds;
			pday_s1 <= 51'(stamp.payload.epoch_seconds[31:7]) * 51'(DAY_RECIP);
		end
		if (ctrl.load[1]) begin
			tlo_s2  <= t_s1[16:0];
			dsec_s2 <= 17'(33'(days) * 33'(SECS_PER_DAY));
			d2_s2   <= days + 16'(EPOCH_REBASE) + 16'((days >= SKIP_LEAP_DAY) ? 1 : 0);
			wx_s2   <= days + 16'(EPOCH_WEEKDAY);
		end
		if (ctrl.load[2]) begin
			rem_s3  <= tlo_s2 - dsec_s2;
			pcyc_s3 <= 33'(d2_s2) * 33'(CYCLE_RECIP);
			pwk_s3  <= 33'(wx_s2) * 33'(WEEK_RECIP);
			d2_s3   <= d2_s2;
			wx_s3   <= wx_s2;
		end
		if (ctrl.load[3]) begin
			phr_s4  <= 34'(rem_s3) * 34'(HOUR_RECIP);
			rem_s4  <= rem_s3;
			cyc_s4  <= cyc;
			r_s4    <= 11'(d2_s3 - 16'(cyc) * 16'(CYCLE_DAYS));
			wday_s4 <= 3'(wx_s3 - 16'(wq) * 16'(WEEK_DAYS));
		end
		if (ctrl.load[4]) begin
			hour_s5 <= hour;
			rem2_s5 <= 12'(rem_s4 - 17'(hour) * 17'(SECS_PER_HOUR));
			doy_s5  <= 9'(r_s4 - ystart);
			leap_s5 <= (yoff == 2'd0);
			year_s5 <= YEAR_BASE + 12'({cyc_s4, 2'b00}) + 12'(yoff);
			wday_s5 <= wday_s4;
		end
		if (ctrl.load[5]) begin
			pmin_s6 <= 25'(rem2_s5) * 25'(MIN_RECIP);
			rem2_s6 <= rem2_s5;
			hour_s6 <= hour_s5;
			doy_s6  <= doy_s5;
			leap_s6 <= leap_s5;
			mon_s6  <= mon;
			year_s6 <= year_s5;
			wday_s6 <= wday_s5;
		end
		if (ctrl.load[6]) begin
			out_s7.second_of_minute <= 6'(rem2_s6 - 12'(minute) * 12'(SECS_PER_MIN));
			out_s7.minute_of_hour   <= minute;
			out_s7.hour_of_day      <= hour_s6;
			out_s7.day_of_month     <= 5'(doy_s6 - month_start(mon_s6, leap_s6) + 9'd1);
			out_s7.day_of_week      <= wday_s6;
			out_s7.month_number     <= mon_s6 + 4'd1;
			out_s7.full_year        <= year_s6;
		end
	end

	assign calendar.payload = out_s7;
endmodule

// ----- tb/sv/epoch_to_calendar_converter_tb.sv -----
// ----------------------------------------------------------------------------
// epoch_to_calendar_converter_tb
// Self-checking bench for the Unix-seconds to UTC calendar converter.
// Sends epoch counts over the stamp channel and predicts each calendar
// result with a year/month stepping calculation that uses the Gregorian leap
// rule. Every accepted result is compared field by field, in order, with the
// oldest prediction. Directed edge cases come first: field extremes, leap
// days, the 2100 century year and the top of the 32-bit range. Random
// requests follow under three sender/receiver idle mixes, with long output
// stalls in two of them and a full drain after each.
// ----------------------------------------------------------------------------
module epoch_to_calendar_converter_tb
	import e2c_pkg::*;
();

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int HOLD_CYCLES    = 60;
	localparam int DRAIN_CYCLES   = 20;
	localparam int PHASE_ITEMS    = 450;

	class calendar_scoreboard;
		calendar_t expected_dates[$];
		int        mismatches;
		int        checked;

		function new();
			mismatches = 0;
			checked    = 0;
		endfunction

		function bit is_leap_year(int unsigned year);
			if (year % 4 != 0)
				return 1'b0;
			if (year % 100 != 0)
				return 1'b1;
			return (year % 400) == 0;
		endfunction

		function int unsigned days_in_month(int unsigned month, int unsigned year);
			case (month)
				1:       return is_leap_year(year) ? 29 : 28;
				3, 5, 8, 10: return 30;
				default: return 31;
			endcase
		endfunction

		function calendar_t calendar_of(logic [31:0] seconds);
			calendar_t   date;
			int unsigned days;
			int unsigned year;
			int unsigned month;
			int unsigned year_len;
			days  = seconds / 86400;
			year  = 1970;
			month = 0;
			date.second_of_minute = 6'(seconds % 60);
			date.minute_of_hour   = 6'((seconds / 60) % 60);
			date.hour_of_day      = 5'((seconds / 3600) % 24);
			date.day_of_week      = 3'((days + 4) % 7);
			forever begin
				year_len = is_leap_year(year) ? 366 : 365;
				if (days < year_len)
					break;
				days -= year_len;
				year++;
			end
			while (month < 11 && days >= days_in_month(month, year)) begin
				days -= days_in_month(month, year);
				month++;
			end
			date.day_of_month = 5'(days + 1);
			date.month_number = 4'(month + 1);
			date.full_year    = 12'(year);
			return date;
		endfunction

		function void note_stamp(stamp_t stamp);
			expected_dates.push_back(calendar_of(stamp.epoch_seconds));
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s: expected %0d, actual %0d", name, want, got);
				mismatches++;
			end
		endfunction

		function void check_calendar(calendar_t got);
			calendar_t want;
			if (expected_dates.size() == 0) begin
				$error("calendar: result with no request outstanding");
				mismatches++;
				return;
			end
			want = expected_dates.pop_front();
			checked++;
			compare_field("second_of_minute", want.second_of_minute, got.second_of_minute);
			compare_field("minute_of_hour", want.minute_of_hour, got.minute_of_hour);
			compare_field("hour_of_day", want.hour_of_day, got.hour_of_day);
			compare_field("day_of_month", want.day_of_month, got.day_of_month);
			compare_field("day_of_week", want.day_of_week, got.day_of_week);
			compare_field("month_number", want.month_number, got.month_number);
			compare_field("full_year", want.full_year, got.full_year);
		endfunction

		function int outstanding();
			return expected_dates.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	e2c_stream_if #(.payload_t(stamp_t))    stamp_if ();
	e2c_stream_if #(.payload_t(calendar_t)) calendar_if ();

	epoch_to_calendar_converter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.stamp    (stamp_if),
		.calendar (calendar_if)
	);

	calendar_scoreboard sb = new();

	int tx_idle_pct;
	int rx_idle_pct;
	bit hold_request;
	int idle_cycles;

	logic [31:0] directed_stamps[] = '{
		32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'd59, 32'd60, 32'd3599, 32'd3600,
		32'd86399, 32'd86400, 32'd2592000, 32'd31535999, 32'd68169600,
		32'd94694399, 32'd951782400, 32'd978220800, 32'd2147483647,
		32'd2147483648, 32'd4102444799, 32'd4102444800, 32'd4107542399,
		32'd4107542400, 32'd4133980799, 32'd4133980800
	};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// note accepted requests and check results
	always @(posedge clk) begin
		if (arst_n && stamp_if.valid && stamp_if.ready)
			sb.note_stamp(stamp_if.payload);
		if (arst_n && calendar_if.valid && calendar_if.ready)
			sb.check_calendar(calendar_if.payload);
	end

	always @(posedge clk) begin
		if ((stamp_if.valid && stamp_if.ready) || (calendar_if.valid && calendar_if.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no request accepted for %0d cycles", WATCHDOG_LIMIT);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// drive ready; hold it low for a long stretch on request
	initial begin
		calendar_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				calendar_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end else begin
				calendar_if.ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	task automatic send_stamp(input logic [31:0] seconds);
		while ($urandom_range(99) < tx_idle_pct) begin
			stamp_if.valid <= 1'b0;
			@(posedge clk);
		end
		stamp_if.valid                 <= 1'b1;
		stamp_if.payload.epoch_seconds <= seconds;
		do @(posedge clk); while (!stamp_if.ready);
	endtask

	task automatic wait_drained();
		stamp_if.valid <= 1'b0;
		do @(posedge clk); while (sb.outstanding() != 0);
	endtask

	function automatic logic [31:0] random_stamp();
		logic [31:0] day;
		day = $urandom_range(0, 49710);
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return $urandom;
			5, 6:          return day * 86400 + ($urandom_range(0, 1) ? 86399 : 0);
			7:             return $urandom_range(32'd4102444800, 32'd4133980799);
			8:             return $urandom_range(32'd4294000000, 32'hFFFF_FFFF);
			default:       return $urandom_range(0, 200000);
		endcase
	endfunction

	task automatic run_phase(input int tx_pct, input int rx_pct, input bit with_hold);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		for (int i = 0; i < PHASE_ITEMS; i++) begin
			if (with_hold && i == 100)
				hold_request = 1'b1;
			send_stamp(random_stamp());
		end
		wait_drained();
	endtask

	initial begin
		arst_n                  <= 1'b0;
		stamp_if.valid          <= 1'b0;
		stamp_if.payload        <= '0;
		tx_idle_pct             = 38;
		rx_idle_pct             = 51;
		hold_request            = 1'b0;
		idle_cycles             = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_stamps[i])
			send_stamp(directed_stamps[i]);
		wait_drained();

		run_phase(38, 51, 1'b1);
		run_phase(51, 38, 1'b0);
		run_phase(0, 0, 1'b1);

		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("checked %0d calendar results: field extremes, leap days, year 2100,",
			sb.checked);
		$display("top of the 32-bit range, a long output stall and three idle mixes");
		if (sb.mismatches == 0 && sb.outstanding() == 0) begin
			$display("end of test: clean");
		end else begin
			if (sb.outstanding() != 0)
				$error("calendar: %0d expected results never arrived", sb.outstanding());
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
